// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the timed message queue RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked at every rising edge outside reset
`define TMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every rising edge, reset included
`define TMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TMQ_ASSERT(lbl, prop, msg)
`define TMQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/tmq_pkg.sv =====
// Types and codes of the timed message queue.
// No dependencies; used by tmq_cell and timed_message_queue.
package tmq_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_POLL   = 2'd2,
    REQ_STOP   = 2'd3
  } req_type_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_QUIT = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // What the cell row does in a cycle
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_POP    = 2'd2
  } cell_mode_e;

  localparam int unsigned TimeW = 63;
  localparam int unsigned NameW = 16;
  localparam int unsigned TokW  = 16;
  localparam int unsigned TotW  = 5;

  // One queued message
  typedef struct packed {
    logic [TimeW-1:0] handle_time;
    logic [NameW-1:0] msg_name;
    logic [TokW-1:0]  msg_token;
  } slot_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic       en;
    cell_mode_e mode;
    slot_t      key;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [NameW-1:0] msg_name;
    logic [TokW-1:0]  msg_token;
    logic [TimeW-1:0] handle_time;
    logic [TimeW-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             popped_valid;
    logic [NameW-1:0] popped_name;
    logic [TokW-1:0]  popped_token;
    logic [TimeW-1:0] popped_time;
    logic [TimeW-1:0] wait_ms;
    logic [TotW-1:0]  entry_total;
  } rsp_t;

endpackage

// ===== rtl/core/tmq_cell.sv =====
// One slot of the sorted queue: holds a message and shifts with its neighbours.
// Depends on tmq_pkg.
module tmq_cell import tmq_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      head_i,   // first cell of the row
  input  logic      occ_i,    // slot holds a message
  input  logic      at_fill_i, // slot is the first free one
  input  logic      hit_i,    // some earlier cell hit
  input  slot_t     prev_i,
  input  slot_t     next_i,
  output logic      hit_o,
  output slot_t     slot_o
);

  slot_t slot_q, slot_d;
  logic  own_hit;

  // Local match: for insert a later due time (at the head also an equal one, or a zero key time), same name for delete
  always_comb begin
    own_hit = 1'b0;
    case (ctl_i.mode)
      MODE_INSERT: begin
        if (head_i) begin
          own_hit = occ_i && ((ctl_i.key.handle_time == '0) ||
                              (ctl_i.key.handle_time <= slot_q.handle_time));
        end else begin
          own_hit = occ_i && (slot_q.handle_time > ctl_i.key.handle_time);
        end
      end
      MODE_DELETE: own_hit = occ_i && (slot_q.msg_name == ctl_i.key.msg_name);
      default:     own_hit = 1'b0;
    endcase
  end

  assign hit_o = hit_i | own_hit;

  // Next slot content
  always_comb begin
    slot_d = slot_q;
    if (ctl_i.en) begin
      case (ctl_i.mode)
        MODE_INSERT: begin
          if (hit_i) begin
            slot_d = prev_i;
          end else if (own_hit || at_fill_i) begin
            slot_d = ctl_i.key;
          end
        end
        MODE_DELETE: begin
          if (hit_i || own_hit) begin
            slot_d = next_i;
          end
        end
        MODE_POP: slot_d = next_i;
        default:  slot_d = slot_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ===== rtl/core/timed_message_queue.sv =====
// Timed message queue: sorted by due time, held in a row of shifting cells.
// Results are registered; a delete first removes each matching entry in turn, then
// finishes. One request in flight: a new one is taken only when idle, and a result
// held by back-pressure holds off the next one.
// Reset: queue emptied, quit cleared, empty wait set to 30000 ms; slot data kept.
// Depends on tmq_pkg, tmq_cell and assert_macros.svh.
`include "assert_macros.svh"

module timed_message_queue import tmq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e         state_q, state_d;
  req_t           req_q;
  rsp_t           rsp_q, rsp_d;
  logic           rsp_valid_q, rsp_valid_d;
  logic [CntW-1:0] count_q, count_d;
  logic           quit_q, quit_d;
  logic [31:0]    empty_wait_q;
  logic           finish;
  logic           out_free;
  cell_ctl_t      ctl;
  slot_t          cell_slot [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] hit;
  logic [CntW+TotW-1:0] total_ext;

  assign req_ready_o = (state_q == ST_IDLE);
  assign out_free    = !rsp_valid_q || rsp_ready_i;

  // Cell row
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t prev_s, next_s;
    if (i == 0) begin : g_first
      assign prev_s = '0;
    end else begin : g_mid
      assign prev_s = cell_slot[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_inner
      assign next_s = cell_slot[i+1];
    end
    tmq_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .head_i    (i == 0),
      .occ_i     (count_q > CntW'(i)),
      .at_fill_i (count_q == CntW'(i)),
      .hit_i     (hit[i]),
      .prev_i    (prev_s),
      .next_i    (next_s),
      .hit_o     (hit[i+1]),
      .slot_o    (cell_slot[i])
    );
  end

  // Request execution
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    quit_d      = quit_q;
    finish      = 1'b0;
    rsp_d       = '0;
    ctl.en      = 1'b0;
    ctl.mode    = MODE_INSERT;
    ctl.key.handle_time = req_q.handle_time;
    ctl.key.msg_name    = req_q.msg_name;
    ctl.key.msg_token   = req_q.msg_token;
    rsp_d.status = STAT_DONE;

    unique case (req_q.req_type)
      REQ_INSERT: ctl.mode = MODE_INSERT;
      REQ_DELETE: ctl.mode = MODE_DELETE;
      default:    ctl.mode = MODE_POP;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_q.req_type == REQ_DELETE && hit[QUEUE_DEPTH]) begin
          // remove the first matching entry this cycle
          ctl.en  = 1'b1;
          count_d = count_q - 1'b1;
        end else if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
          unique case (req_q.req_type)
            REQ_INSERT: begin
              if (quit_q) begin
                rsp_d.status = STAT_QUIT;
              end else if (count_q >= CntW'(QUEUE_DEPTH)) begin
                rsp_d.status = STAT_FULL;
              end else begin
                ctl.en  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            REQ_DELETE: rsp_d.status = STAT_DONE;
            REQ_POLL: begin
              if (quit_q) begin
                rsp_d.status = STAT_QUIT;
              end else if (count_q == '0) begin
                rsp_d.wait_ms = TimeW'(empty_wait_q);
              end else if (req_q.now_time < cell_slot[0].handle_time) begin
                rsp_d.wait_ms = cell_slot[0].handle_time - req_q.now_time;
              end else begin
                ctl.en             = 1'b1;
                count_d            = count_q - 1'b1;
                rsp_d.popped_valid = 1'b1;
                rsp_d.popped_name  = cell_slot[0].msg_name;
                rsp_d.popped_token = cell_slot[0].msg_token;
                rsp_d.popped_time  = cell_slot[0].handle_time;
              end
            end
            REQ_STOP: quit_d = 1'b1;
            default:  rsp_d.status = STAT_DONE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase

    total_ext         = {{TotW{1'b0}}, count_d};
    rsp_d.entry_total = total_ext[TotW-1:0];
  end

  // Result register valid
  always_comb begin
    if (finish) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      quit_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
      empty_wait_q <= 32'd30000;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      quit_q      <= quit_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        empty_wait_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    if (finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Checks
  `TMQ_ASSERT(a_head_sorted,
    (count_q >= CntW'(2)) |-> (cell_slot[0].handle_time <= cell_slot[1].handle_time),
    "queue head out of order")
  `TMQ_ASSERT(a_delete_shrinks,
    (state_q == ST_EXEC && req_q.req_type == REQ_DELETE) |=> (count_q <= $past(count_q)),
    "delete grew the queue")
  `TMQ_ASSERT(a_insert_grows,
    (finish && req_q.req_type == REQ_INSERT && rsp_d.status == STAT_DONE)
      |=> (count_q == $past(count_q) + 1'b1),
    "insert did not add an entry")
  `TMQ_ASSERT(a_pop_done,
    (rsp_valid_o && rsp_o.popped_valid) |-> (rsp_o.status == STAT_DONE),
    "pop with failure status")
  `TMQ_ASSERT(a_count_bound, count_q <= CntW'(QUEUE_DEPTH), "entry count beyond depth")

endmodule

// ===== test/tb_timed_message_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for timed_message_queue: directed and random requests,
// each result checked against a queue model kept in the testbench.
// Depends on tmq_pkg and the timed_message_queue RTL.
module tb_timed_message_queue;
  import tmq_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 16;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned IDLE_SETTLE     = 4;
  localparam int unsigned END_SETTLE      = 40;
  localparam int unsigned RANDOM_PHASES   = 5;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam logic [TimeW-1:0] TIME_MAX   = '1;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  req_t        req_i       = '0;
  logic        rsp_valid_o;
  logic        rsp_ready_i = 1'b0;
  rsp_t        rsp_o;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  // Queue model state
  slot_t       held_slots [QUEUE_DEPTH];
  int unsigned held_count = 0;
  bit          has_quit   = 1'b0;
  logic [31:0] empty_wait = 32'd30000;

  rsp_t        expected_rsps [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          no_gaps        = 1'b0;
  int unsigned stall_left     = 0;

  timed_message_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed_message_queue verification failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none in steady stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Result side back-pressure
  always @(posedge clk_i) begin
    if (no_gaps) begin
      stall_left = 0;
      rsp_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  // Applies one request to the queue model and returns the result it gives
  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    int unsigned pos;
    int unsigned wr;
    res = '0;
    case (req_type_e'(r.req_type))
      REQ_INSERT: begin
        if (has_quit) begin
          res.status = STAT_QUIT;
        end else if (held_count >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          // zero time or not later than head: goes first, else after equal times
          if (held_count == 0 || r.handle_time == '0 ||
              r.handle_time <= held_slots[0].handle_time) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < held_count && held_slots[pos].handle_time <= r.handle_time) pos++;
          end
          for (int i = held_count; i > pos; i--) held_slots[i] = held_slots[i-1];
          held_slots[pos].handle_time = r.handle_time;
          held_slots[pos].msg_name    = r.msg_name;
          held_slots[pos].msg_token   = r.msg_token;
          held_count++;
          res.status = STAT_DONE;
        end
      end
      REQ_DELETE: begin
        // compact out every entry with this name
        wr = 0;
        for (int rd = 0; rd < held_count; rd++) begin
          if (held_slots[rd].msg_name != r.msg_name) begin
            held_slots[wr] = held_slots[rd];
            wr++;
          end
        end
        held_count = wr;
        res.status = STAT_DONE;
      end
      REQ_POLL: begin
        if (has_quit) begin
          res.status = STAT_QUIT;
        end else if (held_count == 0) begin
          res.wait_ms = TimeW'(empty_wait);
        end else if (r.now_time < held_slots[0].handle_time) begin
          res.wait_ms = held_slots[0].handle_time - r.now_time;
        end else begin
          res.popped_valid = 1'b1;
          res.popped_name  = held_slots[0].msg_name;
          res.popped_token = held_slots[0].msg_token;
          res.popped_time  = held_slots[0].handle_time;
          for (int i = 1; i < held_count; i++) held_slots[i-1] = held_slots[i];
          held_count--;
        end
      end
      default: begin
        has_quit = 1'b1;
        res.status = STAT_DONE;
      end
    endcase
    res.entry_total = TotW'(held_count);
    return res;
  endfunction

  // Check each result transfer against the oldest expectation
  task automatic compare_field(input string field, input logic [TimeW-1:0] want,
                               input logic [TimeW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_rsps.pop_front();
        compare_field("status", TimeW'(want.status), TimeW'(rsp_o.status));
        compare_field("popped_valid", TimeW'(want.popped_valid), TimeW'(rsp_o.popped_valid));
        compare_field("popped_name", TimeW'(want.popped_name), TimeW'(rsp_o.popped_name));
        compare_field("popped_token", TimeW'(want.popped_token), TimeW'(rsp_o.popped_token));
        compare_field("popped_time", want.popped_time, rsp_o.popped_time);
        compare_field("wait_ms", want.wait_ms, rsp_o.wait_ms);
        compare_field("entry_total", TimeW'(want.entry_total), TimeW'(rsp_o.entry_total));
      end
    end
  end

  // Request transfer; valid stays up afterwards until the next gap or wait_idle
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    expected_rsps.push_back(apply_request(r));
  endtask

  task automatic wait_idle();
    req_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic set_empty_wait(input logic [31:0] value);
    wait_idle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    empty_wait = value;
  endtask

  // Stimulus helpers
  function automatic logic [TimeW-1:0] rand63();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(0, 5))
      0:       return TimeW'($urandom_range(0, 15));
      1, 2:    return TimeW'($urandom_range(1000, 1015));
      3:       return rand63();
      4:       return TIME_MAX - TimeW'($urandom_range(0, 7));
      default: return TimeW'($urandom());
    endcase
  endfunction

  // Now times around the head, so that polls both pop and wait
  function automatic logic [TimeW-1:0] poll_time();
    logic [TimeW-1:0] head;
    if (held_count == 0 || $urandom_range(0, 99) < 20) return rand_time();
    head = held_slots[0].handle_time;
    case ($urandom_range(0, 4))
      0: return head;
      1: return (head > TIME_MAX - 5) ? TIME_MAX : head + TimeW'($urandom_range(0, 5));
      2: begin
        if (head == '0) return head;
        if (head < 20) return head - TimeW'($urandom_range(1, int'(head)));
        return head - TimeW'($urandom_range(1, 20));
      end
      3: return TIME_MAX;
      default: return rand_time();
    endcase
  endfunction

  function automatic logic [NameW-1:0] pick_name();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h0002;
      3:       return 16'h00A5;
      4:       return 16'h8000;
      5:       return 16'hFFFF;
      default: return NameW'($urandom());
    endcase
  endfunction

  function automatic req_t filler_req();
    req_t r;
    r.req_type    = REQ_STOP;
    r.msg_name    = NameW'($urandom());
    r.msg_token   = TokW'($urandom());
    r.handle_time = rand63();
    r.now_time    = rand63();
    return r;
  endfunction

  function automatic req_t insert_req(input logic [NameW-1:0] name,
                                      input logic [TokW-1:0] token,
                                      input logic [TimeW-1:0] due);
    req_t r;
    r = filler_req();
    r.req_type    = REQ_INSERT;
    r.msg_name    = name;
    r.msg_token   = token;
    r.handle_time = due;
    return r;
  endfunction

  function automatic req_t poll_req(input logic [TimeW-1:0] now);
    req_t r;
    r = filler_req();
    r.req_type = REQ_POLL;
    r.now_time = now;
    return r;
  endfunction

  function automatic req_t delete_req(input logic [NameW-1:0] name);
    req_t r;
    r = filler_req();
    r.req_type = REQ_DELETE;
    r.msg_name = name;
    return r;
  endfunction

  // Bias 0 fills the queue, 1 drains it, 2 is balanced
  function automatic req_t random_request(input int unsigned bias);
    int unsigned pick, ins_pct, poll_pct;
    case (bias)
      0:       begin ins_pct = 65; poll_pct = 25; end
      1:       begin ins_pct = 25; poll_pct = 65; end
      default: begin ins_pct = 45; poll_pct = 45; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) return insert_req(pick_name(), TokW'($urandom()), rand_time());
    if (pick < ins_pct + poll_pct) return poll_req(poll_time());
    // deletes mostly hit a held name
    if (held_count > 0 && $urandom_range(0, 99) < 60)
      return delete_req(held_slots[$urandom_range(0, held_count - 1)].msg_name);
    return delete_req(pick_name());
  endfunction

  // Tests
  task automatic test_empty_poll();
    send_request(poll_req(TIME_MAX));
    wait_idle();
  endtask

  task automatic test_time_ordering();
    send_request(insert_req(16'h0000, 16'hFFFF, 63'd100));
    send_request(insert_req(16'hFFFF, 16'h0000, 63'd50));   // not later than head
    send_request(insert_req(16'h0001, 16'h0001, 63'd100));  // after an equal time
    send_request(insert_req(16'h0002, 16'h0002, '0));       // zero time goes first
    send_request(insert_req(16'h0003, 16'h0003, TIME_MAX));
    send_request(insert_req(16'h0004, 16'h0004, 63'd50));
    send_request(poll_req('0));                              // head due at once
    send_request(poll_req(63'd10));                          // head not yet due
    send_request(poll_req(63'd50));
    wait_idle();
  endtask

  task automatic test_delete_by_name();
    send_request(insert_req(16'h0005, 16'h1111, 63'd60));
    send_request(insert_req(16'h0005, 16'h2222, 63'd60));
    send_request(delete_req(16'h0005));   // adjacent matches
    send_request(delete_req(16'h1234));   // no match
    wait_idle();
  endtask

  task automatic test_full_queue();
    while (held_count < QUEUE_DEPTH)
      send_request(insert_req(pick_name(), TokW'($urandom()), rand_time()));
    send_request(insert_req(16'hFFFF, 16'hFFFF, 63'd1));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned bias;
    bias = 2;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       set_empty_wait(32'd0);
        1:       set_empty_wait(32'hFFFF_FFFF);
        3:       set_empty_wait(32'd1);
        default: set_empty_wait($urandom());
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          bias    = $urandom_range(0, 2);
          no_gaps = ($urandom_range(0, 4) == 0);
        end
        send_request(random_request(bias));
      end
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // Runs last: the quit state is never left
  task automatic test_stop();
    req_t stop;
    stop = filler_req();
    send_request(insert_req(16'h0007, 16'h0007, 63'd5));
    send_request(stop);
    send_request(insert_req(16'h0008, 16'h0008, 63'd5));
    send_request(poll_req(TIME_MAX));
    send_request(delete_req(16'h0007));   // delete still works after quit
    send_request(stop);
    send_request(poll_req('0));
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_poll();
    test_time_ordering();
    test_delete_by_name();
    test_full_queue();
    test_random_traffic();
    test_stop();
    wait_idle();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("timed_message_queue verification clean");
    end else begin
      $display("timed_message_queue verification failed");
    end
    $finish;
  end

endmodule
